// ===== sv/gray_threshold_blur_colour_map_assert.svh =====
// Assertion macros for the gray_threshold_blur_colour_map checker.
// Expects signals named clk and rst_n in the scope of use.
`ifndef GRAY_THRESHOLD_BLUR_COLOUR_MAP_ASSERT_SVH
`define GRAY_THRESHOLD_BLUR_COLOUR_MAP_ASSERT_SVH

// same-cycle implication
`define GTBC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gtbc: same-cycle check failed");

// next-cycle implication
`define GTBC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gtbc: next-cycle check failed");

`endif

// ===== sv/gtbc_pkg.sv =====
// Shared types and constants of the gray/threshold/blur/false-colour block.
// No dependencies.
`default_nettype none

package gtbc_pkg;

  localparam int unsigned MIN_DIM    = 4;
  localparam int unsigned RST_WIDTH  = 640;
  localparam int unsigned RST_HEIGHT = 480;
  localparam int unsigned RST_BLACK  = 100;
  localparam int unsigned RST_WHITE  = 160;

  // luma weights (per mille) and reciprocal of 1000 for a 28-bit shift
  localparam logic [17:0] W_RED      = 18'd299;
  localparam logic [17:0] W_GREEN    = 18'd587;
  localparam logic [17:0] W_BLUE     = 18'd114;
  localparam logic [18:0] GRAY_RECIP = 19'd268436;
  localparam int unsigned GRAY_SHIFT = 28;

  // 3/25 as multiply by 15729 and 17-bit shift, exact for sums up to 2040
  localparam logic [13:0] BLUR_MUL   = 14'd15729;
  localparam int unsigned BLUR_SHIFT = 17;

  localparam logic [7:0] RED_OFS   = 8'd204;
  localparam logic [7:0] GREEN_OFS = 8'd180;
  localparam logic [7:0] BLUE_OFS  = 8'd200;
  localparam logic [7:0] ALPHA_ON  = 8'd250;

  localparam int unsigned OUT_DEPTH = 8;

  typedef enum logic [1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_BLACK  = 2'd2,
    CFG_WHITE  = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic pixel;    // carries real pixel data
    logic result;   // item produces a result
    logic zero_px;  // result is for pixel 0
    logic blur_en;  // result position is inside the blur region
    logic last;     // result is the final pixel of the frame
  } item_ctl_t;

  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } px_out_t;

endpackage

`default_nettype wire

// ===== sv/gtbc_line_mem.sv =====
// Two-row line store: one synchronous write port, one read port, registered read.
// Write-first forwarding when both ports hit the same entry. No dependencies.
`default_nettype none

module gtbc_line_mem #(
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [15:0]              rdata,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [15:0]              wdata
);

  logic [15:0] mem [DEPTH];
  logic [15:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= (we && (waddr == raddr)) ? wdata : mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== sv/gtbc_ctrl.sv =====
// Configuration registers and frame position tracking for input and output.
// Depends on gtbc_pkg.
`default_nettype none

module gtbc_ctrl #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [1:0]                   cfg_addr,
  input  logic [12:0]                  cfg_wdata,
  input  logic                         item_fire,
  input  logic                         item_flush,
  output logic                         take,
  output gtbc_pkg::item_ctl_t          ctl,
  output logic [$clog2(MAX_WIDTH)-1:0] col,
  output logic [7:0]                   black_thr,
  output logic [7:0]                   white_thr
);

  import gtbc_pkg::*;

  localparam int AW  = $clog2(MAX_WIDTH);
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int HW  = $clog2(MAX_HEIGHT + 1);
  localparam int IRW = $clog2(MAX_HEIGHT + 2);
  localparam int ORW = $clog2(MAX_HEIGHT);
  localparam int unsigned W_RST = (RST_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RST_WIDTH;
  localparam int unsigned H_RST = (RST_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : RST_HEIGHT;

  logic [WW-1:0]  w_r;
  logic [HW-1:0]  h_r;
  logic [7:0]     black_r, white_r;
  logic [AW-1:0]  in_col_r, out_col_r;
  logic [IRW-1:0] in_row_r;
  logic [ORW-1:0] out_row_r;

  logic [31:0] w32, h32, icol32, irow32, ocol32, orow32;
  logic [31:0] wv, hv, w_sat, h_sat;
  logic        done, started;

  always_comb begin
    w32    = 32'(w_r);
    h32    = 32'(h_r);
    icol32 = 32'(in_col_r);
    irow32 = 32'(in_row_r);
    ocol32 = 32'(out_col_r);
    orow32 = 32'(out_row_r);

    done    = irow32 >= h32;
    started = (irow32 >= 32'd2) || ((irow32 == 32'd1) && (icol32 != 32'd0));
    take    = item_fire && !(item_flush && !done);

    ctl.pixel   = !done;
    ctl.result  = started;
    ctl.zero_px = (orow32 == 32'd0) && (ocol32 == 32'd0);
    ctl.blur_en = (orow32 >= 32'd2) && (orow32 + 32'd2 <= h32) &&
                  (ocol32 >= 32'd2) && (ocol32 + 32'd2 <= w32);
    ctl.last    = (orow32 + 32'd1 == h32) && (ocol32 + 32'd1 == w32);

    wv    = 32'(cfg_wdata[10:0]);
    hv    = 32'(cfg_wdata[12:0]);
    w_sat = wv;
    h_sat = hv;
    if (wv < MIN_DIM) begin
      w_sat = MIN_DIM;
    end else if (wv > 32'(MAX_WIDTH)) begin
      w_sat = 32'(MAX_WIDTH);
    end
    if (hv < MIN_DIM) begin
      h_sat = MIN_DIM;
    end else if (hv > 32'(MAX_HEIGHT)) begin
      h_sat = 32'(MAX_HEIGHT);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r       <= WW'(W_RST);
      h_r       <= HW'(H_RST);
      black_r   <= 8'(RST_BLACK);
      white_r   <= 8'(RST_WHITE);
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_addr))
        CFG_WIDTH:  w_r     <= WW'(w_sat);
        CFG_HEIGHT: h_r     <= HW'(h_sat);
        CFG_BLACK:  black_r <= cfg_wdata[7:0];
        CFG_WHITE:  white_r <= cfg_wdata[7:0];
      endcase
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
    end else if (take) begin
      if (ctl.result && ctl.last) begin
        in_col_r  <= '0;
        in_row_r  <= '0;
        out_col_r <= '0;
        out_row_r <= '0;
      end else begin
        if (icol32 + 32'd1 >= w32) begin
          in_col_r <= '0;
          in_row_r <= in_row_r + 1'b1;
        end else begin
          in_col_r <= in_col_r + 1'b1;
        end
        if (ctl.result) begin
          if (ocol32 + 32'd1 >= w32) begin
            out_col_r <= '0;
            out_row_r <= out_row_r + 1'b1;
          end else begin
            out_col_r <= out_col_r + 1'b1;
          end
        end
      end
    end
  end

  assign col       = in_col_r;
  assign black_thr = black_r;
  assign white_thr = white_r;

endmodule

`default_nettype wire

// ===== sv/gtbc_pix.sv =====
// Pixel datapath: luma, threshold, line store update, 3x3 window, blur and
// false colour. Depends on gtbc_pkg and gtbc_line_mem.
`default_nettype none

module gtbc_pix #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         take,
  input  gtbc_pkg::item_ctl_t          ctl_in,
  input  logic [$clog2(MAX_WIDTH)-1:0] col_in,
  input  logic [7:0]                   red_in,
  input  logic [7:0]                   green_in,
  input  logic [7:0]                   blue_in,
  input  logic [7:0]                   black_thr,
  input  logic [7:0]                   white_thr,
  output logic                         push,
  output gtbc_pkg::px_out_t            push_data,
  output logic                         push_last
);

  import gtbc_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);

  // stage 1: weighted sum
  logic            v1_r;
  item_ctl_t       ctl1_r;
  logic [AW-1:0]   col1_r;
  logic [17:0]     sum1_r;
  logic [17:0]     sum0;

  // stage 2: raw gray, line store data
  logic            v2_r;
  item_ctl_t       ctl2_r;
  logic [AW-1:0]   col2_r;
  logic [7:0]      gray2_r;
  logic [36:0]     prod1;
  logic [15:0]     mem_rd;
  logic [7:0]      gray_lo, gray_t, top, mid, bot;
  logic            mem_we;

  // stage 3: window
  logic            v3_r;
  item_ctl_t       ctl3_r;
  logic [7:0]      win_r [3][3];
  logic [10:0]     sum8;

  // stage 4: neighbour sum
  logic            v4_r;
  item_ctl_t       ctl4_r;
  logic [10:0]     sum4_r;
  logic [24:0]     bmul;
  logic [7:0]      blur_nxt;

  // stage 5: blur and colour
  logic            v5_r;
  item_ctl_t       ctl5_r;
  logic [7:0]      blur5_r;
  logic [7:0]      prev_blur_r;
  px_out_t         col_out;

  assign sum0 = 18'(red_in) * W_RED + 18'(green_in) * W_GREEN + 18'(blue_in) * W_BLUE;
  assign prod1 = 37'(sum1_r) * 37'(GRAY_RECIP);

  always_comb begin
    gray_lo = (gray2_r < black_thr) ? 8'd0 : gray2_r;
    gray_t  = (gray_lo > white_thr) ? 8'hFF : gray_lo;
    top     = ctl2_r.pixel ? mem_rd[15:8] : 8'd0;
    mid     = ctl2_r.pixel ? mem_rd[7:0] : 8'd0;
    bot     = ctl2_r.pixel ? gray_t : 8'd0;
    mem_we  = v2_r && ctl2_r.pixel;
  end

  gtbc_line_mem #(
    .DEPTH (MAX_WIDTH)
  ) u_line_mem (
    .clk   (clk),
    .re    (v1_r && ctl1_r.pixel),
    .raddr (col1_r),
    .rdata (mem_rd),
    .we    (mem_we),
    .waddr (col2_r),
    .wdata ({mid, gray_t})
  );

  always_comb begin
    sum8 = 11'(win_r[0][0]) + 11'(win_r[0][1]) + 11'(win_r[0][2]) +
           11'(win_r[1][0]) + 11'(win_r[1][2]) +
           11'(win_r[2][0]) + 11'(win_r[2][1]) + 11'(win_r[2][2]);
  end

  assign bmul     = 25'(sum4_r) * 25'(BLUR_MUL);
  assign blur_nxt = ctl4_r.blur_en ? bmul[BLUR_SHIFT+7:BLUR_SHIFT] : 8'd0;

  always_comb begin
    if (ctl5_r.zero_px) begin
      col_out = '0;
    end else begin
      col_out.red   = blur5_r + prev_blur_r + {1'b0, prev_blur_r[7:1]} + RED_OFS;
      col_out.green = GREEN_OFS + blur5_r;
      col_out.blue  = BLUE_OFS + {blur5_r[6:0], 1'b0};
      col_out.alpha = ALPHA_ON;
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      v1_r <= take;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r && ctl3_r.result;
      v5_r <= v4_r;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    ctl1_r  <= ctl_in;
    col1_r  <= col_in;
    sum1_r  <= sum0;
    ctl2_r  <= ctl1_r;
    col2_r  <= col1_r;
    gray2_r <= prod1[GRAY_SHIFT+7:GRAY_SHIFT];
    ctl3_r  <= ctl2_r;
    ctl4_r  <= ctl3_r;
    sum4_r  <= sum8;
    ctl5_r  <= ctl4_r;
    blur5_r <= blur_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 3; k++) begin
        for (int j = 0; j < 3; j++) begin
          win_r[k][j] <= 8'd0;
        end
      end
      prev_blur_r <= 8'd0;
    end else begin
      if (v2_r) begin
        for (int k = 0; k < 3; k++) begin
          win_r[k][0] <= win_r[k][1];
          win_r[k][1] <= win_r[k][2];
        end
        win_r[0][2] <= top;
        win_r[1][2] <= mid;
        win_r[2][2] <= bot;
      end
      if (v5_r) begin
        prev_blur_r <= blur5_r;
      end
    end
  end

  assign push      = v5_r;
  assign push_data = col_out;
  assign push_last = ctl5_r.last;

endmodule

`default_nettype wire

// ===== sv/gtbc_out_fifo.sv =====
// Output queue with slot reservation at input transfer time.
// Depends on gtbc_pkg.
`default_nettype none

module gtbc_out_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              reserve,
  input  logic              push,
  input  gtbc_pkg::px_out_t push_data,
  input  logic              push_last,
  output logic              out_valid,
  input  logic              out_ready,
  output gtbc_pkg::px_out_t out_data,
  output logic              out_last,
  output logic              credit_ok
);

  import gtbc_pkg::*;

  localparam int PW = $clog2(OUT_DEPTH);

  px_out_t       data_q [OUT_DEPTH];
  logic          last_q [OUT_DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [PW:0]   cnt_r, resv_r;
  logic          pop;

  assign out_valid = cnt_r != '0;
  assign pop       = out_valid && out_ready;
  assign out_data  = data_q[rd_ptr_r];
  assign out_last  = last_q[rd_ptr_r];
  assign credit_ok = resv_r < (PW+1)'(OUT_DEPTH);

  always_ff @(posedge clk) begin
    if (push) begin
      data_q[wr_ptr_r] <= push_data;
      last_q[wr_ptr_r] <= push_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
      resv_r   <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r  <= cnt_r + (PW+1)'(push) - (PW+1)'(pop);
      resv_r <= resv_r + (PW+1)'(reserve) - (PW+1)'(pop);
    end
  end

endmodule

`default_nettype wire

// ===== sv/gray_threshold_blur_colour_map.sv =====
// Pixel stream to false colour: one RGB pixel (or flush) per input transfer,
// at most one RGBA result per transfer. Sustains one transfer per clock; the
// rate is set by the line store RAM (one read and one write per cycle) and an
// 8-entry output queue whose slots are reserved on input, so in_tready drops
// only when eight results are pending. A result lags its pixel by W+1 input
// transfers and, after the transfer that completes it, passes through the
// pipeline stages into the output queue. After the last pixel of a frame,
// W+1 further transfers (flush or pixel, data ignored) drain the tail,
// the final one marked by tlast. The line store needs no clearing pass after
// reset. Configuration writes restart the frame and must only be issued while
// the block is idle. Depends on gtbc_pkg, gtbc_ctrl, gtbc_pix, gtbc_out_fifo.
`default_nettype none

module gray_threshold_blur_colour_map #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [12:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // in_red, in_green, in_blue
  input  logic        in_tuser,   // flush
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // out_red, out_green, out_blue, out_alpha
  output logic        out_tlast   // last_pixel
);

  import gtbc_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);

  logic          in_fire, take, credit_ok, push, push_last;
  item_ctl_t     ctl;
  logic [AW-1:0] col;
  logic [7:0]    black_thr, white_thr;
  px_out_t       push_data, out_data;

  assign in_fire   = in_tvalid && in_tready;
  assign in_tready = credit_ok;

  gtbc_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .item_fire  (in_fire),
    .item_flush (in_tuser),
    .take       (take),
    .ctl        (ctl),
    .col        (col),
    .black_thr  (black_thr),
    .white_thr  (white_thr)
  );

  gtbc_pix #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_pix (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .ctl_in    (ctl),
    .col_in    (col),
    .red_in    (in_tdata[7:0]),
    .green_in  (in_tdata[15:8]),
    .blue_in   (in_tdata[23:16]),
    .black_thr (black_thr),
    .white_thr (white_thr),
    .push      (push),
    .push_data (push_data),
    .push_last (push_last)
  );

  gtbc_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .reserve   (take && ctl.result),
    .push      (push),
    .push_data (push_data),
    .push_last (push_last),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_data),
    .out_last  (out_tlast),
    .credit_ok (credit_ok)
  );

  assign out_tdata = out_data;

endmodule

`default_nettype wire

// ===== sv/gtbc_checker.sv =====
// Port-level checks for gray_threshold_blur_colour_map, bound to the top.
// Depends on gtbc_pkg and gray_threshold_blur_colour_map_assert.svh.
`default_nettype none

`include "gray_threshold_blur_colour_map_assert.svh"

module gtbc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        out_tlast
);

  import gtbc_pkg::*;

  `GTBC_ASSERT_NEXT(a_out_hold_valid, out_tvalid && !out_tready, out_tvalid)
  `GTBC_ASSERT_NEXT(a_out_hold_data, out_tvalid && !out_tready, $stable(out_tdata) && $stable(out_tlast))
  // a frame's final pixel is never pixel 0
  `GTBC_ASSERT_NOW(a_last_opaque, out_tvalid && out_tlast, out_tdata[31:24] == ALPHA_ON)
  // green and blue derive from the same blur value
  `GTBC_ASSERT_NOW(a_green_blue, out_tvalid && out_tdata[31:24] == ALPHA_ON, out_tdata[23:16] == 8'({out_tdata[14:8], 1'b0} + 8'd96))
  `GTBC_ASSERT_NOW(a_pixel_zero, out_tvalid && out_tdata[31:24] != ALPHA_ON, out_tdata == '0 && !out_tlast)

endmodule

bind gray_threshold_blur_colour_map gtbc_checker u_gtbc_checker (.*);

`default_nettype wire
